FILE: hdl/qxmix_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qxmix_pkg
// Types, codes and constants shared by the quad X motor mixer files.
// ----------------------------------------------------------------------------
package qxmix_pkg;

  localparam int unsigned RAMP_DIVIDE_DEF = 2;
  localparam int unsigned DIV_STEPS       = 16;
  localparam int unsigned DIV_CNT_W       = $clog2(DIV_STEPS);

  localparam logic [10:0] THROTTLE_MIN_RST = 11'd48;
  localparam logic [10:0] THROTTLE_MAX_RST = 11'd2047;
  localparam logic [7:0]  RAMP_STEP_RST    = 8'd8;

  localparam logic [15:0] SCALE_ONE = 16'd16384;
  localparam logic [15:0] SCALE_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_IDLE0 = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_IDLE3 = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_THROTTLE_MIN = 2'd0,
    REG_THROTTLE_MAX = 2'd1,
    REG_RAMP_STEP    = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_SCALE,
    OP_MULP,
    OP_MULR,
    OP_TRUNC,
    OP_MIX,
    OP_EXT,
    OP_SHIFT,
    OP_RUN_OUT,
    OP_STOP_OUT
  } dp_op_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [10:0]        base_throttle;
    logic signed [15:0] pitch_corr;
    logic signed [15:0] roll_corr;
  } in_item_t;

  typedef struct packed {
    logic [10:0] motor_one;
    logic [10:0] motor_two;
    logic [10:0] motor_three;
    logic [10:0] motor_four;
    logic        stopping;
  } out_item_t;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] in_mode;
    logic       div_last;
    logic       out_free;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: hdl/qxmix_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qxmix_ctrl
// Sequencer for the mixer: input handshake and datapath step commands.
// ----------------------------------------------------------------------------
module qxmix_ctrl
  import qxmix_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCALE,
    ST_MULP,
    ST_MULR,
    ST_TRUNC,
    ST_MIX,
    ST_EXT,
    ST_SHIFT,
    ST_RUN_OUT,
    ST_STOP_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          if (status_i.in_mode == MODE_RUN) begin
            state_d = ST_DIV;
          end else if (status_i.in_mode == MODE_STOP) begin
            state_d = ST_STOP_OUT;
          end
        end
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        if (status_i.div_last) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd_o.op = OP_SCALE;
        state_d  = ST_MULP;
      end
      ST_MULP: begin
        cmd_o.op = OP_MULP;
        state_d  = ST_MULR;
      end
      ST_MULR: begin
        cmd_o.op = OP_MULR;
        state_d  = ST_TRUNC;
      end
      ST_TRUNC: begin
        cmd_o.op = OP_TRUNC;
        state_d  = ST_MIX;
      end
      ST_MIX: begin
        cmd_o.op = OP_MIX;
        state_d  = ST_EXT;
      end
      ST_EXT: begin
        cmd_o.op = OP_EXT;
        state_d  = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd_o.op = OP_SHIFT;
        state_d  = ST_RUN_OUT;
      end
      ST_RUN_OUT: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_RUN_OUT;
          state_d  = ST_IDLE;
        end
      end
      ST_STOP_OUT: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_STOP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule
`default_nettype wire

FILE: hdl/qxmix_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qxmix_dp
// Mixer datapath: config registers, serial scale divider, shared multiplier,
// mix and desaturation, clamp, ramp-down, motor hold and output register.
// ----------------------------------------------------------------------------
module qxmix_dp
  import qxmix_pkg::*;
#(
  parameter int unsigned RAMP_DIVIDE = RAMP_DIVIDE_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [10:0] cfg_wdata_i,
  input  wire in_item_t    in_data_i,
  input  wire dp_cmd_t     cmd_i,
  output dp_status_t       status_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o
);

  localparam int unsigned PH_W = (RAMP_DIVIDE > 1) ? $clog2(RAMP_DIVIDE) : 1;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(RAMP_DIVIDE - 1);

  // configuration
  logic [10:0] tmin_q, tmax_q;
  logic [7:0]  rstep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmin_q  <= THROTTLE_MIN_RST;
      tmax_q  <= THROTTLE_MAX_RST;
      rstep_q <= RAMP_STEP_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_THROTTLE_MIN: tmin_q  <= cfg_wdata_i;
        REG_THROTTLE_MAX: tmax_q  <= cfg_wdata_i;
        REG_RAMP_STEP:    rstep_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [18:0] trunc_q14(input logic signed [32:0] v);
    logic signed [32:0] adj;
    adj = v + (v[32] ? 33'sd16383 : 33'sd0);
    return adj[32:14];
  endfunction

  function automatic logic [10:0] ramp_one(input logic [10:0] cur, input logic [10:0] lo,
                                           input logic [7:0] step);
    logic [11:0] lim;
    lim = {1'b0, lo} + {4'b0, step};
    if (cur <= lo) begin
      return lo;
    end else if ({1'b0, cur} > lim) begin
      return cur - {3'b0, step};
    end
    return lo;
  endfunction

  // latched item
  logic [10:0]        base_q;
  logic signed [15:0] pc_q, rc_q;

  // divider
  logic [13:0]          divisor_q, rem_q;
  logic [15:0]          quot_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 neg_q, sat_q, den_pos_q;

  // multiply and mix
  logic [15:0]        scale_q;
  logic signed [32:0] prod_q;
  logic signed [18:0] p_q, r_q;
  logic signed [20:0] m_q [4];
  logic signed [20:0] mx_q, mn_q;
  logic signed [21:0] sh_q;

  // state and output
  logic [10:0]     hold_q [4];
  logic [PH_W-1:0] phase_q;
  logic            out_valid_q;
  out_item_t       out_q;

  // load time arithmetic
  logic signed [11:0] num;
  logic [10:0]        abs_num, den;
  logic [13:0]        divisor;

  assign num     = $signed({1'b0, in_data_i.base_throttle}) - $signed({1'b0, tmin_q});
  assign abs_num = num[11] ? 11'(-num) : num[10:0];
  assign den     = tmax_q - tmin_q;
  assign divisor = {1'b0, den, 2'b00} + {3'b0, den};

  // divider step
  logic [14:0] rem_sh;
  logic        ge;
  assign rem_sh = {rem_q, 1'b0};
  assign ge     = rem_sh >= {1'b0, divisor_q};

  // scale
  logic signed [17:0] s18;
  logic [15:0]        scale_new;
  always_comb begin
    s18 = neg_q ? (18'sd16384 - $signed({2'b0, quot_q}))
                : (18'sd16384 + $signed({2'b0, quot_q}));
    if (!den_pos_q) begin
      scale_new = SCALE_ONE;
    end else if (sat_q) begin
      scale_new = neg_q ? 16'd0 : SCALE_MAX;
    end else if (s18 < 0) begin
      scale_new = 16'd0;
    end else if (s18 > $signed({2'b0, SCALE_MAX})) begin
      scale_new = SCALE_MAX;
    end else begin
      scale_new = s18[15:0];
    end
  end

  logic signed [16:0] scale_s;
  assign scale_s = $signed({1'b0, scale_q});

  // mix
  logic signed [20:0] b21, p21, r21;
  assign b21 = $signed({6'b0, base_q, 4'b0});
  assign p21 = {{2{p_q[18]}}, p_q};
  assign r21 = {{2{r_q[18]}}, r_q};

  // min and max
  logic signed [20:0] mx01, mx23, mn01, mn23;
  assign mx01 = (m_q[1] > m_q[0]) ? m_q[1] : m_q[0];
  assign mx23 = (m_q[3] > m_q[2]) ? m_q[3] : m_q[2];
  assign mn01 = (m_q[1] < m_q[0]) ? m_q[1] : m_q[0];
  assign mn23 = (m_q[3] < m_q[2]) ? m_q[3] : m_q[2];

  // desaturation shift
  logic signed [21:0] lo22, hi22, sh_a, t22, sh_new;
  assign lo22   = $signed({7'b0, tmin_q, 4'b0});
  assign hi22   = $signed({7'b0, tmax_q, 4'b0});
  assign sh_a   = (22'(mx_q) > hi22) ? (hi22 - 22'(mx_q)) : 22'sd0;
  assign t22    = 22'(mn_q) + sh_a;
  assign sh_new = (t22 < lo22) ? (lo22 - 22'(mn_q)) : sh_a;

  // clamp and ramp
  logic [10:0] clamp [4];
  logic [10:0] ramp_v [4];
  logic        ramp_now;
  assign ramp_now = (phase_q == PH_LAST);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic signed [21:0] v;
      v = 22'(m_q[i]) + sh_q;
      if (v < lo22) begin
        clamp[i] = tmin_q;
      end else if (v > hi22) begin
        clamp[i] = tmax_q;
      end else begin
        clamp[i] = v[14:4];
      end
      ramp_v[i] = ramp_now ? ramp_one(hold_q[i], tmin_q, rstep_q) : hold_q[i];
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        base_q    <= in_data_i.base_throttle;
        pc_q      <= in_data_i.pitch_corr;
        rc_q      <= in_data_i.roll_corr;
        neg_q     <= num[11];
        den_pos_q <= tmax_q > tmin_q;
        divisor_q <= divisor;
        sat_q     <= {3'b0, abs_num} >= divisor;
        rem_q     <= {3'b0, abs_num};
        quot_q    <= '0;
      end
      OP_DIV: begin
        rem_q  <= ge ? 14'(rem_sh - {1'b0, divisor_q}) : rem_sh[13:0];
        quot_q <= {quot_q[14:0], ge};
      end
      OP_SCALE: scale_q <= scale_new;
      OP_MULP:  prod_q  <= pc_q * scale_s;
      OP_MULR: begin
        p_q    <= trunc_q14(prod_q);
        prod_q <= rc_q * scale_s;
      end
      OP_TRUNC: r_q <= trunc_q14(prod_q);
      OP_MIX: begin
        m_q[0] <= b21 + p21 + r21;
        m_q[1] <= b21 - p21 + r21;
        m_q[2] <= b21 + p21 - r21;
        m_q[3] <= b21 - p21 - r21;
      end
      OP_EXT: begin
        mx_q <= (mx23 > mx01) ? mx23 : mx01;
        mn_q <= (mn23 < mn01) ? mn23 : mn01;
      end
      OP_SHIFT: sh_q <= sh_new;
      OP_RUN_OUT: begin
        out_q.motor_one   <= clamp[0];
        out_q.motor_two   <= clamp[1];
        out_q.motor_three <= clamp[2];
        out_q.motor_four  <= clamp[3];
        out_q.stopping    <= 1'b0;
      end
      OP_STOP_OUT: begin
        out_q.motor_one   <= ramp_v[0];
        out_q.motor_two   <= ramp_v[1];
        out_q.motor_three <= ramp_v[2];
        out_q.motor_four  <= ramp_v[3];
        out_q.stopping    <= 1'b1;
      end
      default: ;
    endcase
  end

  // division step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.op == OP_LOAD) begin
      cnt_q <= '0;
    end else if (cmd_i.op == OP_DIV) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // held motors, ramp phase, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        hold_q[i] <= THROTTLE_MIN_RST;
      end
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_RUN_OUT) begin
        for (int i = 0; i < 4; i++) begin
          hold_q[i] <= clamp[i];
        end
      end else if (cmd_i.op == OP_STOP_OUT) begin
        for (int i = 0; i < 4; i++) begin
          hold_q[i] <= ramp_v[i];
        end
        phase_q <= ramp_now ? '0 : phase_q + 1'b1;
      end
      if (cmd_i.op == OP_RUN_OUT || cmd_i.op == OP_STOP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.in_mode  = in_data_i.mode;
  assign status_o.div_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: hdl/quad_x_motor_mixer_desat_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_desat_top
// Quadcopter X motor mixer with desaturation and stop-mode ramp-down.
// ----------------------------------------------------------------------------
// A run item (mode 1) is handled one item at a time: the input is held off
// until its result has been placed in the output register. Its steps are the
// bit-serial divider that forms the throttle-dependent gain, then gain, the
// two multiplies on one shared multiplier, truncation of the second product,
// mix, min/max, shift and clamp. A stop item (mode 2) goes straight to the
// ramp-down and output step; other modes are taken without holding off the
// input and give nothing. Results sit in an output register, so the next item
// is taken while a result waits; a new result waits only when the previous
// one has not been taken yet.
// ----------------------------------------------------------------------------
module quad_x_motor_mixer_desat_top
  import qxmix_pkg::*;
#(
  parameter int unsigned RAMP_DIVIDE = RAMP_DIVIDE_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [10:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  qxmix_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  qxmix_dp #(
    .RAMP_DIVIDE (RAMP_DIVIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  // a result only appears after a busy cycle
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a busy cycle");

  // a run item holds off the next item
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.mode == MODE_RUN) |=> in_stall_o)
    else $error("run item did not hold off input");

  // an idle-mode item gives no result
  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.mode != MODE_RUN
     && in_data_i.mode != MODE_STOP) |=> (!$rose(out_valid_o) && !in_stall_o))
    else $error("idle-mode item produced activity");
`endif

endmodule
`default_nettype wire

FILE: bench/quad_x_motor_mixer_desat_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_desat_top_tb
// Drives control ticks into the quad X mixer and predicts every result on the
// side. The prediction covers throttle-dependent gain, X mixing, the
// desaturating shift, the clamp and the stop-mode ramp-down of held motors.
// Limit registers are changed between phases while the block is idle. Both
// handshakes idle at random, and the output is held off once for a long
// stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module quad_x_motor_mixer_desat_top_tb;
  import qxmix_pkg::*;

  localparam int unsigned STOP_TICK_DIV  = RAMP_DIVIDE_DEF;
  localparam int unsigned PHASE_ITEMS    = 193;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned HOLD_AT_RESULT = 300;
  localparam int unsigned HOLD_CYCLES    = 400;

  class motor_scoreboard;
    logic [10:0]  thr_min;
    logic [10:0]  thr_max;
    logic [7:0]   ramp_dec;
    logic [10:0]  held[4];
    int unsigned  stop_ticks;
    out_item_t    motor_q[$];

    function new();
      thr_min  = THROTTLE_MIN_RST;
      thr_max  = THROTTLE_MAX_RST;
      ramp_dec = RAMP_STEP_RST;
      foreach (held[i]) held[i] = THROTTLE_MIN_RST;
      stop_ticks = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [10:0] val);
      case (idx)
        REG_THROTTLE_MIN: thr_min = val;
        REG_THROTTLE_MAX: thr_max = val;
        REG_RAMP_STEP:    ramp_dec = val[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return motor_q.size();
    endfunction

    // predicts the result of one accepted item
    function void note_input(in_item_t it);
      longint base, pc, rc, num, den, scl, p, r, b, mx, mn, sh, lo, hi, v;
      longint m[4];
      out_item_t want;
      lo = longint'(thr_min) * 16;
      hi = longint'(thr_max) * 16;
      if (it.mode == MODE_RUN) begin
        base = longint'(it.base_throttle);
        pc   = longint'($signed(it.pitch_corr));
        rc   = longint'($signed(it.roll_corr));
        num  = base - longint'(thr_min);
        den  = longint'(thr_max) - longint'(thr_min);
        scl  = 16384;
        if (den > 0) scl = 16384 + (65536 * num) / (5 * den);
        if (scl < 0) scl = 0;
        if (scl > 65535) scl = 65535;
        p = (pc * scl) / 16384;
        r = (rc * scl) / 16384;
        b = base * 16;
        m[0] = b + p + r;
        m[1] = b - p + r;
        m[2] = b + p - r;
        m[3] = b - p - r;
        mx = m[0];
        mn = m[0];
        for (int i = 1; i < 4; i++) begin
          if (m[i] > mx) mx = m[i];
          if (m[i] < mn) mn = m[i];
        end
        sh = 0;
        if (mx > hi) sh = hi - mx;
        if (mn + sh < lo) sh += lo - (mn + sh);
        for (int i = 0; i < 4; i++) begin
          v = m[i] + sh;
          if (v < lo) held[i] = thr_min;
          else if (v > hi) held[i] = thr_max;
          else held[i] = 11'(v / 16);
        end
        want.stopping = 1'b0;
      end else if (it.mode == MODE_STOP) begin
        stop_ticks++;
        if (stop_ticks >= STOP_TICK_DIV) begin
          stop_ticks = 0;
          for (int i = 0; i < 4; i++) begin
            if (held[i] <= thr_min) held[i] = thr_min;
            else if (int'(held[i]) > int'(thr_min) + int'(ramp_dec))
              held[i] = held[i] - 11'(ramp_dec);
            else held[i] = thr_min;
          end
        end
        want.stopping = 1'b1;
      end else begin
        return;
      end
      want.motor_one   = held[0];
      want.motor_two   = held[1];
      want.motor_three = held[2];
      want.motor_four  = held[3];
      motor_q.push_back(want);
    endfunction

    // empty string when the result matches the oldest prediction
    function string check_result(out_item_t got);
      out_item_t want;
      string msg;
      msg = "";
      if (motor_q.size() == 0) return $sformatf("unexpected result %h", got);
      want = motor_q.pop_front();
      if (got.motor_one !== want.motor_one)
        msg = {msg, $sformatf(" motor_one %0d exp %0d", got.motor_one, want.motor_one)};
      if (got.motor_two !== want.motor_two)
        msg = {msg, $sformatf(" motor_two %0d exp %0d", got.motor_two, want.motor_two)};
      if (got.motor_three !== want.motor_three)
        msg = {msg, $sformatf(" motor_three %0d exp %0d", got.motor_three,
                              want.motor_three)};
      if (got.motor_four !== want.motor_four)
        msg = {msg, $sformatf(" motor_four %0d exp %0d", got.motor_four, want.motor_four)};
      if (got.stopping !== want.stopping)
        msg = {msg, $sformatf(" stopping %0b exp %0b", got.stopping, want.stopping)};
      return msg;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = REG_THROTTLE_MIN;
  logic [10:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  out_item_t   out_data;

  motor_scoreboard sb;
  int unsigned     err_cnt = 0;
  bit              tx_quiet = 1'b0;
  bit              rx_quiet = 1'b0;
  bit              rx_took = 1'b0;

  always #1 clk = ~clk;

  quad_x_motor_mixer_desat_top #(
    .RAMP_DIVIDE(STOP_TICK_DIV)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t:%s", $realtime, msg);
    err_cnt++;
  endtask

  always @(posedge clk) begin : result_mon
    string msg;
    if (rst_n && out_valid && !out_stall) begin
      msg = sb.check_result(out_data);
      if (msg != "") report_mismatch(msg);
      rx_took = 1'b1;
    end
  end

  // output side: random stall per result, plus one long hold-off
  initial begin : rx_proc
    int unsigned wait_cnt;
    int unsigned hold_cnt;
    int unsigned taken;
    wait_cnt = 0;
    hold_cnt = 0;
    taken = 0;
    forever begin
      @(negedge clk);
      if (rx_took) begin
        rx_took = 1'b0;
        taken++;
        if ($urandom_range(0, 39) == 0) rx_quiet = ($urandom_range(0, 3) == 0);
        wait_cnt = rx_quiet ? 0 : $urandom_range(0, 5);
        if (taken == HOLD_AT_RESULT) hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (wait_cnt > 0) begin
        if (out_valid) wait_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_item_t mk_item(mode_e md, int base, int pc, int rc);
    in_item_t it;
    it.mode          = md;
    it.base_throttle = 11'(base);
    it.pitch_corr    = 16'(pc);
    it.roll_corr     = 16'(rc);
    return it;
  endfunction

  function automatic logic [15:0] rand_corr();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 16'($urandom);
    if (sel < 8) return 16'(int'($urandom_range(0, 1600)) - 800);
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_quiet = ($urandom_range(0, 3) == 0);
    gap = tx_quiet ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [10:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_limits(logic [10:0] lo, logic [10:0] hi, logic [10:0] dec);
    write_reg(REG_THROTTLE_MIN, lo);
    write_reg(REG_THROTTLE_MAX, hi);
    write_reg(REG_RAMP_STEP, dec);
    if ($urandom_range(0, 1) == 1) write_reg(REG_UNUSED, 11'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int unsigned n_items);
    int unsigned counted;
    int          sel;
    int          v;
    mode_e       md;
    in_item_t    it;
    counted = 0;
    md = MODE_RUN;
    while (counted < n_items) begin
      if ($urandom_range(0, 11) == 0) begin
        sel = $urandom_range(0, 19);
        if (sel < 10) md = MODE_RUN;
        else if (sel < 17) md = MODE_STOP;
        else if (sel < 19) md = MODE_IDLE0;
        else md = MODE_IDLE3;
      end
      sel = $urandom_range(0, 9);
      if (sel < 5) v = $urandom_range(0, 2047);
      else if (sel < 7) v = int'(sb.thr_min) + int'($urandom_range(0, 40)) - 20;
      else if (sel < 9) v = int'(sb.thr_max) + int'($urandom_range(0, 40)) - 20;
      else v = ($urandom_range(0, 1) == 1) ? 2047 : 0;
      if (v < 0) v = 0;
      if (v > 2047) v = 2047;
      it.mode          = md;
      it.base_throttle = 11'(v);
      it.pitch_corr    = rand_corr();
      it.roll_corr     = rand_corr();
      send_item(it);
      counted++;
    end
  endtask

  initial begin : stim
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset limits: held motors start at the minimum
    send_item(mk_item(MODE_STOP, 0, 0, 0));
    send_item(mk_item(MODE_STOP, 2047, -1, -1));
    send_item(mk_item(MODE_IDLE0, 2047, 32767, -32768));
    send_item(mk_item(MODE_IDLE3, 0, -32768, 32767));
    send_item(mk_item(MODE_RUN, 0, 0, 0));
    send_item(mk_item(MODE_RUN, 0, -32768, 32767));
    send_item(mk_item(MODE_RUN, 2047, 32767, 32767));
    send_item(mk_item(MODE_RUN, 2047, -32768, -32768));
    send_item(mk_item(MODE_RUN, 1024, 32767, -32768));
    send_item(mk_item(MODE_RUN, 1024, 100, -50));
    send_item(mk_item(MODE_RUN, 2047, 0, 0));
    send_item(mk_item(MODE_STOP, 0, 0, 0));
    send_item(mk_item(MODE_STOP, 0, 0, 0));
    send_item(mk_item(MODE_STOP, 0, 0, 0));
    send_item(mk_item(MODE_STOP, 0, 0, 0));
    // remaining distance not above the step lands on the minimum
    send_item(mk_item(MODE_RUN, 60, 0, 0));
    send_item(mk_item(MODE_STOP, 0, 0, 0));
    send_item(mk_item(MODE_STOP, 0, 0, 0));
    send_item(mk_item(MODE_STOP, 0, 0, 0));
    send_item(mk_item(MODE_STOP, 0, 0, 0));
    send_item(mk_item(MODE_RUN, 47, 16, -16));
    send_item(mk_item(MODE_IDLE3, 2047, -1, -1));
    drain();

    set_limits(11'd48, 11'd2047, 11'd8);
    run_random(PHASE_ITEMS);
    drain();
    set_limits(11'd0, 11'd2047, 11'd255);
    run_random(PHASE_ITEMS);
    drain();
    set_limits(11'd2047, 11'd1, 11'd0);
    run_random(PHASE_ITEMS);
    drain();
    set_limits(11'd1000, 11'd1000, 11'd16);
    run_random(PHASE_ITEMS);
    drain();
    set_limits(11'd0, 11'd100, 11'd37);
    run_random(PHASE_ITEMS);
    drain();
    set_limits(11'd1000, 11'd1100, 11'd200);
    run_random(PHASE_ITEMS);
    drain();
    set_limits(11'd1500, 11'd200, 11'd3);
    run_random(PHASE_ITEMS);
    drain();
    set_limits(11'($urandom_range(0, 400)), 11'($urandom_range(1500, 2047)),
               11'($urandom));
    run_random(PHASE_ITEMS);
    drain();
    set_limits(11'($urandom_range(0, 2047)), 11'($urandom_range(1, 2047)),
               11'($urandom));
    run_random(PHASE_ITEMS);
    drain();
    set_limits(11'($urandom_range(100, 300)), 11'($urandom_range(1800, 2000)),
               11'($urandom_range(0, 40)));
    run_random(PHASE_ITEMS);
    drain();

    if (sb.pending() != 0) report_mismatch(" predicted results left over");
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("TIMEOUT: run did not finish in time");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
